[hw/rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared codes and types of the software timer table: operation codes,
// timer state codes, the layout of one table entry and the structs that
// travel between the top level and the entry update logic.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int TICK_W = 32;
    localparam int ID_W   = 4;

    localparam logic [1:0] OP_SCAN   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]        state;
        logic              periodic;
        logic [TICK_W-1:0] match;
        logic [TICK_W-1:0] period;
    } stt_entry_t;

    localparam int ENTRY_W = $bits(stt_entry_t);

    typedef struct packed {
        logic [1:0]        op;
        logic              act;
        logic              periodic;
        logic [TICK_W-1:0] delay;
        logic [TICK_W-1:0] tick;
    } stt_cmd_t;

    typedef struct packed {
        logic       we;
        stt_entry_t wentry;
        logic       fired;
        logic [1:0] state_read;
    } stt_upd_t;

endpackage

[hw/rtl/software_timer_table_top.sv]
// ----------------------------------------------------------------------------
// software_timer_table_top
// Table of software timers held in one RAM. Each item reads its entry,
// updates it and writes it back, giving one result item.
//
//   Channel  Direction  Ports
//   s_       in         operation, timer_id, periodic, delay_ticks, current_tick
//   m_       out        fired, fired_id, state_read
//
// Each item has its RAM read at acceptance and its update and write-back in
// the update stage, so one item is in the table at a time.
// The next item is accepted while a result waits in the output register.
// A stalled result holds the update stage until the output register frees.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module software_timer_table_top
    import stt_pkg::*;
#(
    parameter int TIMER_COUNT = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [ID_W-1:0]   s_timer_id,
    input  logic              s_periodic,
    input  logic [TICK_W-1:0] s_delay_ticks,
    input  logic [TICK_W-1:0] s_current_tick,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_fired,
    output logic [ID_W-1:0]   m_fired_id,
    output logic [1:0]        m_state_read
);

    localparam int IDX_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int SCAN_W = $clog2(TIMER_COUNT + 1);

    logic              acc;
    logic              ex_go;
    logic              is_scan;
    logic              scan_wrap;
    logic              id_ok;
    logic              act;
    logic [IDX_W-1:0]  rd_addr;
    stt_entry_t        ram_rdata;
    stt_entry_t        ent;
    stt_cmd_t          cmd;
    stt_upd_t          upd;

    logic [SCAN_W-1:0]      scan_reg, scan_next;
    logic                   ex_valid_reg, ex_valid_next;
    stt_cmd_t               cmd_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic                   vld_rd_reg;
    logic [TIMER_COUNT-1:0] valid_reg, valid_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_fired_reg;
    logic [ID_W-1:0]        m_fired_id_reg;
    logic [1:0]             m_state_read_reg;

    assign s_ready   = !ex_valid_reg;
    assign acc       = s_valid && s_ready;
    assign ex_go     = ex_valid_reg && (!m_valid_reg || m_ready);
    assign is_scan   = (s_operation == OP_SCAN);
    assign scan_wrap = (scan_reg == SCAN_W'(TIMER_COUNT));
    assign id_ok     = (32'(s_timer_id) < 32'(TIMER_COUNT));
    assign act       = is_scan ? !scan_wrap : id_ok;
    assign rd_addr   = is_scan ? scan_reg[IDX_W-1:0] : IDX_W'(s_timer_id);

    always_comb begin
        cmd.op       = s_operation;
        cmd.act      = act;
        cmd.periodic = s_periodic;
        cmd.delay    = s_delay_ticks;
        cmd.tick     = s_current_tick;
    end

    stt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TIMER_COUNT)
    ) u_ram (
        .clk  (aclk),
        .we   (ex_go && upd.we),
        .waddr(addr_reg),
        .wdata(upd.wentry),
        .re   (acc),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    assign ent = vld_rd_reg ? ram_rdata : stt_entry_t'('0);

    stt_update u_update (
        .cmd(cmd_reg),
        .ent(ent),
        .upd(upd)
    );

    always_comb begin
        scan_next = scan_reg;
        if (acc && is_scan) begin
            scan_next = scan_wrap ? '0 : scan_reg + SCAN_W'(1);
        end

        ex_valid_next = ex_valid_reg;
        if (acc) begin
            ex_valid_next = 1'b1;
        end else if (ex_go) begin
            ex_valid_next = 1'b0;
        end

        valid_next = valid_reg;
        if (ex_go && upd.we) begin
            valid_next[addr_reg] = 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (ex_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= '0;
            ex_valid_reg <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            scan_reg     <= scan_next;
            ex_valid_reg <= ex_valid_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            cmd_reg    <= cmd;
            addr_reg   <= rd_addr;
            vld_rd_reg <= act && valid_reg[rd_addr];
        end
        if (ex_go) begin
            m_fired_reg      <= upd.fired;
            m_fired_id_reg   <= upd.fired ? ID_W'(addr_reg) : '0;
            m_state_read_reg <= upd.state_read;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_fired      = m_fired_reg;
    assign m_fired_id   = m_fired_id_reg;
    assign m_state_read = m_state_read_reg;

endmodule

[hw/rtl/stt_ram.sv]
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/stt_update.sv]
// ----------------------------------------------------------------------------
// stt_update
// Read-modify-write logic for one table entry: scan visit, create, stop
// and read, giving the entry to write back and the result of the item.
// ----------------------------------------------------------------------------
module stt_update
    import stt_pkg::*;
(
    input  stt_cmd_t   cmd,
    input  stt_entry_t ent,
    output stt_upd_t   upd
);

    always_comb begin
        upd        = '0;
        upd.wentry = ent;
        if (cmd.act) begin
            unique case (cmd.op)
                OP_SCAN: begin
                    upd.we = 1'b1;
                    if (ent.state == ST_RUNNING) begin
                        if (ent.match <= cmd.tick) begin
                            upd.wentry.state = ST_TIMEOUT;
                            upd.fired        = 1'b1;
                        end
                    end else if (ent.state == ST_TIMEOUT) begin
                        if (ent.periodic) begin
                            upd.wentry.match = cmd.tick + ent.period;
                            upd.wentry.state = ST_RUNNING;
                        end else begin
                            upd.wentry.state = ST_STOPPED;
                        end
                    end
                end
                OP_CREATE: begin
                    upd.we              = 1'b1;
                    upd.wentry.state    = ST_RUNNING;
                    upd.wentry.periodic = cmd.periodic;
                    upd.wentry.match    = cmd.tick + cmd.delay;
                    upd.wentry.period   = cmd.delay;
                end
                OP_STOP: begin
                    upd.we           = 1'b1;
                    upd.wentry.state = ST_STOPPED;
                end
                OP_READ: begin
                    upd.state_read = ent.state;
                end
            endcase
        end
    end

endmodule

[hw/rtl/stt_checker.sv]
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the software timer table, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_fired,
    input logic [ID_W-1:0]   m_fired_id,
    input logic [1:0]        m_state_read
);

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The table takes one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another is in the table");

    // A fire comes only from a scan step, which reports no state.
    a_fire_no_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fired |-> m_state_read == ST_STOPPED)
        else $error("fire reported together with a state");

    a_no_fire_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fired |-> m_fired_id == '0)
        else $error("timer index without a fire");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fired)
            && $stable(m_fired_id) && $stable(m_state_read))
        else $error("stalled item changed");

endmodule

bind software_timer_table_top stt_checker u_stt_checker (.*);

[verif/software_timer_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives create, stop, read and scan commands into the timer table. The
// commands are a short directed sequence, then random traffic on an advancing
// tick. A local copy of the table predicts each result item, and the monitor
// compares the items it receives, in order, with those predictions. Both
// channels insert random idle cycles.
// ----------------------------------------------------------------------------
module testbench;
    import stt_pkg::*;

    localparam int TIMER_COUNT = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [1:0]        op;
        logic [ID_W-1:0]   id;
        logic              per;
        logic [TICK_W-1:0] delay;
        logic [TICK_W-1:0] tick;
        int                gap;
        bit                drain;
    } timer_cmd_t;

    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] fired_id;
        logic [1:0]      state_read;
    } timer_report_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_operation = OP_SCAN;
    logic [ID_W-1:0]   s_timer_id = '0;
    logic              s_periodic = 1'b0;
    logic [TICK_W-1:0] s_delay_ticks = '0;
    logic [TICK_W-1:0] s_current_tick = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_fired;
    logic [ID_W-1:0]   m_fired_id;
    logic [1:0]        m_state_read;

    timer_cmd_t    cmd_queue[$];
    timer_report_t due_reports[$];

    logic [1:0]        tbl_state[TIMER_COUNT];
    logic              tbl_periodic[TIMER_COUNT];
    logic [TICK_W-1:0] tbl_match[TIMER_COUNT];
    logic [TICK_W-1:0] tbl_period[TIMER_COUNT];
    logic [4:0]        scan_ptr;

    int unsigned op_count[4];
    int unsigned expiry_count;
    int unsigned wrap_count;
    int unsigned pause_count;
    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned results_seen;
    int          gap_left;
    int          stall_left;
    int          in_mode;
    int          out_mode;
    timer_report_t want;
    timer_report_t got;

    software_timer_table_top #(
        .TIMER_COUNT(TIMER_COUNT)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_timer_id    (s_timer_id),
        .s_periodic    (s_periodic),
        .s_delay_ticks (s_delay_ticks),
        .s_current_tick(s_current_tick),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fired       (m_fired),
        .m_fired_id    (m_fired_id),
        .m_state_read  (m_state_read)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_wait(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    function automatic void add_cmd(logic [1:0] op, logic [ID_W-1:0] id, logic per,
                                    logic [TICK_W-1:0] delay, logic [TICK_W-1:0] tick,
                                    bit drain);
        timer_cmd_t c;
        c.op    = op;
        c.id    = id;
        c.per   = per;
        c.delay = delay;
        c.tick  = tick;
        c.gap   = pick_wait(in_mode);
        c.drain = drain;
        cmd_queue.push_back(c);
    endfunction

    function automatic timer_report_t advance_timer_table(timer_cmd_t c);
        timer_report_t r;
        int            idx;
        r = '0;
        idx = scan_ptr;
        op_count[c.op]++;
        if (c.op == OP_SCAN) begin
            if (scan_ptr < TIMER_COUNT) begin
                if (tbl_state[idx] == ST_RUNNING) begin
                    if (tbl_match[idx] <= c.tick) begin
                        tbl_state[idx] = ST_TIMEOUT;
                        r.fired = 1'b1;
                        r.fired_id = scan_ptr[ID_W-1:0];
                        expiry_count++;
                    end
                end else if (tbl_state[idx] == ST_TIMEOUT) begin
                    if (!tbl_periodic[idx]) begin
                        tbl_state[idx] = ST_STOPPED;
                    end else begin
                        tbl_match[idx] = c.tick + tbl_period[idx];
                        tbl_state[idx] = ST_RUNNING;
                    end
                end
                scan_ptr = scan_ptr + 5'd1;
            end else begin
                scan_ptr = '0;
                wrap_count++;
            end
        end else if (c.id < TIMER_COUNT) begin
            case (c.op)
                OP_CREATE: begin
                    tbl_match[c.id]    = c.tick + c.delay;
                    tbl_period[c.id]   = c.delay;
                    tbl_state[c.id]    = ST_RUNNING;
                    tbl_periodic[c.id] = c.per;
                end
                OP_STOP: begin
                    tbl_state[c.id] = ST_STOPPED;
                end
                default: begin
                    r.state_read = tbl_state[c.id];
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                due_reports.push_back(advance_timer_table(cmd_queue[0]));
                cmd_queue.delete(0);
                if (cmd_queue.size() > 0) begin
                    gap_left = cmd_queue[0].gap;
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (cmd_queue.size() > 0 &&
                             (!cmd_queue[0].drain || due_reports.size() == 0)) begin
                    if (cmd_queue[0].drain) begin
                        pause_count++;
                    end
                    s_valid        <= 1'b1;
                    s_operation    <= cmd_queue[0].op;
                    s_timer_id     <= cmd_queue[0].id;
                    s_periodic     <= cmd_queue[0].per;
                    s_delay_ticks  <= cmd_queue[0].delay;
                    s_current_tick <= cmd_queue[0].tick;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_fired, m_fired_id, m_state_read};
                if (due_reports.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result item, actual fired %0d id %0d state %0d",
                             $time, got.fired, got.fired_id, got.state_read);
                end else begin
                    want = due_reports[0];
                    due_reports.delete(0);
                    if (want !== got) begin
                        error_count++;
                        $display("%0t: mismatch, expected fired/id/state %0d/%0d/%0d, %s",
                                 $time, want.fired, want.fired_id, want.state_read,
                                 $sformatf("actual %0d/%0d/%0d",
                                           got.fired, got.fired_id, got.state_read));
                    end
                end
                results_seen++;
                if (results_seen % 37 == 0) begin
                    out_mode = $urandom_range(0, 2);
                end
                stall_left = pick_wait(out_mode);
                m_ready <= (stall_left == 0);
            end else if (!m_ready) begin
                if (stall_left <= 1) begin
                    stall_left = 0;
                    m_ready <= 1'b1;
                end else begin
                    stall_left = stall_left - 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [TICK_W-1:0] tick_now;
        logic [TICK_W-1:0] delay;
        logic [1:0]        op;
        int                pick;

        for (int i = 0; i < TIMER_COUNT; i++) begin
            tbl_state[i]    = ST_STOPPED;
            tbl_periodic[i] = 1'b0;
            tbl_match[i]    = '0;
            tbl_period[i]   = '0;
        end
        scan_ptr = '0;
        gap_left = 0;
        stall_left = 0;
        out_mode = 2;
        in_mode = 2;

        // A zero delay, a create whose match wraps past the top of the tick
        // range, and a full scan round that ends with the pointer reset step.
        add_cmd(OP_READ, 4'd0, 1'b0, '0, '0, 1'b0);
        add_cmd(OP_CREATE, 4'd0, 1'b0, '0, '0, 1'b0);
        add_cmd(OP_CREATE, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_CREATE, 4'd1, 1'b0, 32'd5, 32'hFFFF_FFFE, 1'b0);
        add_cmd(OP_READ, 4'd0, 1'b1, 32'hFFFF_FFFF, '0, 1'b0);
        add_cmd(OP_STOP, 4'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_SCAN, 4'd0, 1'b0, '0, 32'd10, 1'b0);
        add_cmd(OP_READ, 4'd0, 1'b0, '0, 32'd10, 1'b0);
        add_cmd(OP_SCAN, 4'd15, 1'b1, '0, 32'd100, 1'b0);
        for (int i = 2; i < TIMER_COUNT; i++) begin
            add_cmd(OP_SCAN, i[3:0], 1'b0, '0, (i == 15) ? 32'hFFFF_FFFF : 32'd100, 1'b0);
        end
        add_cmd(OP_SCAN, 4'd0, 1'b0, '0, 32'd200, 1'b0);
        add_cmd(OP_SCAN, 4'd0, 1'b0, '0, 32'd200, 1'b1);

        tick_now = 32'd1000;
        for (int n = 0; n < 900; n++) begin
            if (n % 40 == 0) begin
                in_mode = $urandom_range(0, 2);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                tick_now = $urandom;
            end else if (pick < 3) begin
                tick_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
            end else begin
                tick_now = tick_now + $urandom_range(0, 3);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                op = OP_SCAN;
            end else if (pick < 75) begin
                op = OP_CREATE;
            end else if (pick < 83) begin
                op = OP_STOP;
            end else begin
                op = OP_READ;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                delay = '0;
            end else if (pick < 75) begin
                delay = $urandom_range(1, 40);
            end else if (pick < 85) begin
                delay = $urandom_range(41, 500);
            end else if (pick < 95) begin
                delay = $urandom;
            end else begin
                delay = 32'hFFFF_FFFF - $urandom_range(0, 15);
            end
            add_cmd(op, ID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), delay,
                    tick_now, (n == 300 || n == 650 || $urandom_range(0, 199) == 0));
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (cmd_queue.size() > 0 || due_reports.size() > 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("Covered %0d scans (%0d pointer resets), %0d creates, %0d stops, %0d reads.",
                 op_count[OP_SCAN], wrap_count, op_count[OP_CREATE], op_count[OP_STOP],
                 op_count[OP_READ]);
        $display("Saw %0d timer expiries, %0d result items and %0d pauses to drain.",
                 expiry_count, results_seen, pause_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
